// File: hw/rtl/aect_pkg.sv
// Package for the active error code table.
// Holds the table size, field widths, command and status codes, item structs
// and the state type. No dependencies.
`default_nettype none

package aect_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int CODE_W = 16;
	localparam int POS_W = 4;
	localparam int TOT_W = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_FIND = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [CODE_W-1:0] error_code;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [POS_W-1:0] position;
		logic [TOT_W-1:0] entry_total;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/aect_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module aect_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/active_error_code_table.sv
// Top level of the active error code table.
// Depends on aect_pkg and aect_ram.
`default_nettype none

// The table holds up to CAPACITY distinct codes in insertion order in one RAM.
// An item is taken when start is high and busy is low. The stored entries are
// scanned one per cycle through the RAM read port until a hit or the end of the
// table. A delete then moves each later entry down by one, one entry per cycle.
// The result is registered: it appears in the cycle after the work ends, on
// result for a single cycle with done high, and must be taken then. busy drops
// in that same cycle.

module active_error_code_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire aect_pkg::in_item_t request,
	output logic done,
	output aect_pkg::out_item_t result
);

	aect_pkg::state_t state_q, state_d;
	aect_pkg::in_item_t req_q;
	logic [aect_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [aect_pkg::CNT_W-1:0] rd_q, rd_d;
	logic [aect_pkg::IDX_W-1:0] where_q, where_d;
	logic v_s1, v_d;
	logic [aect_pkg::IDX_W-1:0] a_s1, a_d;
	logic done_d;
	aect_pkg::out_item_t res_d;

	logic we;
	logic [aect_pkg::IDX_W-1:0] waddr;
	logic [aect_pkg::CODE_W-1:0] wdata;
	logic [aect_pkg::IDX_W-1:0] raddr;
	logic [aect_pkg::CODE_W-1:0] rdata;
	logic issue;
	logic hit_now;

	aect_ram #(
		.WIDTH(aect_pkg::CODE_W),
		.DEPTH(aect_pkg::CAPACITY)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy = (state_q != aect_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		rd_d = rd_q;
		where_d = where_q;
		v_d = 1'b0;
		a_d = rd_q[aect_pkg::IDX_W-1:0];
		done_d = 1'b0;
		res_d = '0;
		we = 1'b0;
		waddr = cnt_q[aect_pkg::IDX_W-1:0];
		wdata = req_q.error_code;
		raddr = rd_q[aect_pkg::IDX_W-1:0];
		issue = (rd_q < cnt_q);
		hit_now = v_s1 && (rdata == req_q.error_code);

		case (state_q)
			aect_pkg::S_IDLE: begin
				if (start) begin
					rd_d = '0;
					state_d = aect_pkg::S_SCAN;
				end
			end
			aect_pkg::S_SCAN: begin
				v_d = issue && !hit_now;
				if (issue) begin
					rd_d = rd_q + 1'b1;
				end
				if (hit_now) begin
					where_d = a_s1;
					res_d.found = 1'b1;
					res_d.position = aect_pkg::POS_W'(a_s1);
					res_d.entry_total = aect_pkg::TOT_W'(cnt_q);
					case (req_q.command)
						aect_pkg::CMD_INSERT: begin
							res_d.status = aect_pkg::ST_PRESENT;
							done_d = 1'b1;
							state_d = aect_pkg::S_IDLE;
						end
						aect_pkg::CMD_DELETE: begin
							v_d = 1'b0;
							rd_d = aect_pkg::CNT_W'(a_s1) + 1'b1;
							state_d = aect_pkg::S_SHIFT;
						end
						default: begin
							res_d.status = aect_pkg::ST_DONE;
							done_d = 1'b1;
							state_d = aect_pkg::S_IDLE;
						end
					endcase
				end else if (!issue && !v_s1) begin
					res_d.entry_total = aect_pkg::TOT_W'(cnt_q);
					res_d.status = aect_pkg::ST_ABSENT;
					if (req_q.command == aect_pkg::CMD_INSERT) begin
						if (cnt_q >= aect_pkg::CNT_W'(aect_pkg::CAPACITY)) begin
							res_d.status = aect_pkg::ST_FULL;
						end else begin
							we = 1'b1;
							cnt_d = cnt_q + 1'b1;
							res_d.entry_total = aect_pkg::TOT_W'(cnt_d);
							res_d.status = aect_pkg::ST_DONE;
						end
					end
					done_d = 1'b1;
					state_d = aect_pkg::S_IDLE;
				end
			end
			aect_pkg::S_SHIFT: begin
				v_d = issue;
				if (issue) begin
					rd_d = rd_q + 1'b1;
				end
				if (v_s1) begin
					we = 1'b1;
					waddr = a_s1 - 1'b1;
					wdata = rdata;
				end
				if (!issue && !v_s1) begin
					cnt_d = cnt_q - 1'b1;
					res_d.found = 1'b1;
					res_d.position = aect_pkg::POS_W'(where_q);
					res_d.entry_total = aect_pkg::TOT_W'(cnt_d);
					res_d.status = aect_pkg::ST_DONE;
					done_d = 1'b1;
					state_d = aect_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = aect_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aect_pkg::S_IDLE;
			cnt_q <= '0;
			rd_q <= '0;
			v_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rd_q <= rd_d;
			v_s1 <= v_d;
			done <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		where_q <= where_d;
		a_s1 <= a_d;
		if (done_d) begin
			result <= res_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/aect_chk.sv
// Port-level checker for the active error code table, bound to the top level.
// Depends on aect_pkg and active_error_code_table.
`default_nettype none

module aect_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire aect_pkg::in_item_t request,
	input wire logic done,
	input wire aect_pkg::out_item_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted item");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result given without an item in progress");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.entry_total <= aect_pkg::TOT_W'(aect_pkg::CAPACITY))
		else $error("entry total exceeds capacity");

	a_miss_position: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.position == '0)
		else $error("nonzero position on a miss");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.found |->
			result.status == aect_pkg::ST_DONE || result.status == aect_pkg::ST_PRESENT)
		else $error("status disagrees with found");

endmodule

bind active_error_code_table aect_chk u_aect_chk (.*);

`default_nettype wire
